// File: rtl/glc_pkg.sv
package glc_pkg;

  localparam int TABLE_ENTRIES = 4096;
  localparam int ADDR_W = $clog2(TABLE_ENTRIES);
  localparam int PAIR_W = 20;
  localparam logic [11:0] TOP_CODE_LIMIT = 12'd4095;
  localparam logic [3:0] MAX_WIDTH = 4'd12;
  localparam logic [3:0] RESET_SIZE = 4'd8;

  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_PUT     = 3'd1,
    OP_DRAIN   = 3'd2,
    OP_FLUSH   = 3'd3,
    OP_RESTART = 3'd4
  } pack_op_t;

  typedef struct packed {
    pack_op_t    op;
    logic [11:0] code;
    logic [3:0]  width;
  } pack_cmd_t;

  function automatic logic [3:0] eff_size(input logic [3:0] v);
    if (v < 4'd2) return 4'd2;
    if (v > 4'd8) return 4'd8;
    return v;
  endfunction

endpackage

// File: rtl/gif_lzw_compressor.sv
// GIF LZW encoder: pixels in, packed code bytes out (LSB first). Each pixel
// after the first scans the dictionary memory one entry per cycle, from the
// first code above the end code up to the highest code or until a match.
// The packed bytes are drained after each pixel, holding while the output is stalled.
// The last pixel adds the end code and a flush of the remaining bytes.
// Writing min_code_size restarts the stream.
module gif_lzw_compressor (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [3:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] pixel,
  input  logic       last_pixel,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] code_byte,
  output logic       stream_end
);

  typedef enum logic [10:0] {
    S_IDLE       = 11'b00000000001,
    S_START      = 11'b00000000010,
    S_SEARCH     = 11'b00000000100,
    S_MISS       = 11'b00000001000,
    S_CLEAR      = 11'b00000010000,
    S_DRAIN      = 11'b00000100000,
    S_DRAIN_WAIT = 11'b00001000000,
    S_LAST       = 11'b00010000000,
    S_END        = 11'b00100000000,
    S_FLUSH      = 11'b01000000000,
    S_FLUSH_WAIT = 11'b10000000000
  } state_t;

  state_t      state;
  logic [3:0]  cs;
  logic [7:0]  px;
  logic        last;
  logic [11:0] prefix_code;
  logic        have_prefix;
  logic [3:0]  chain_length;
  logic [4:0]  short_chain_count;
  logic [11:0] highest_code;
  logic [3:0]  code_width;
  logic [12:0] scan_addr;
  logic [11:0] cmp_addr;
  logic        cmp_valid;

  logic [11:0] clear_code, end_code, highest_next;
  logic [7:0]  px_mask;
  logic [19:0] pair, rd_data;
  logic        wr_en, hit, busy;
  logic [3:0]  cs_new;
  logic [7:0]  chain_x_size;
  glc_pkg::pack_cmd_t cmd;

  assign clear_code   = 12'd1 << cs;
  assign end_code     = clear_code + 12'd1;
  assign px_mask      = 8'((9'd1 << cs) - 9'd1);
  assign pair         = {prefix_code, px};
  assign hit          = cmp_valid && (rd_data == pair);
  assign highest_next = highest_code + 12'd1;
  assign cs_new       = glc_pkg::eff_size(cfg_data);
  assign chain_x_size = {4'd0, chain_length} * {4'd0, cs};
  assign wr_en        = (state == S_MISS) &&
                        (highest_code < 12'(glc_pkg::TABLE_ENTRIES - 1));

  assign in_ready  = (state == S_IDLE) && !cfg_valid;
  assign cfg_ready = (state == S_IDLE);

  glc_dict_ram #(.ADDR_W(glc_pkg::ADDR_W), .DATA_W(glc_pkg::PAIR_W)) u_dict (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (highest_next[glc_pkg::ADDR_W-1:0]),
    .wr_data (pair),
    .rd_addr (scan_addr[glc_pkg::ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  glc_bit_packer u_pack (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .busy       (busy),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .code_byte  (code_byte),
    .stream_end (stream_end)
  );

  always_comb begin
    cmd = '{op: glc_pkg::OP_NONE, code: prefix_code, width: code_width};
    case (state)
      S_IDLE: begin
        if (cfg_valid) begin
          cmd.op    = glc_pkg::OP_RESTART;
          cmd.code  = 12'd1 << cs_new;
          cmd.width = cs_new + 4'd1;
        end
      end
      S_MISS:  cmd.op = glc_pkg::OP_PUT;
      S_CLEAR: begin
        if (short_chain_count > {1'b0, cs} + 5'd8) begin
          cmd.op   = glc_pkg::OP_PUT;
          cmd.code = clear_code;
        end
      end
      S_DRAIN: cmd.op = glc_pkg::OP_DRAIN;
      S_LAST:  begin
        if (last) cmd.op = glc_pkg::OP_PUT;
      end
      S_END: begin
        cmd.op   = glc_pkg::OP_PUT;
        cmd.code = end_code;
      end
      S_FLUSH: cmd.op = glc_pkg::OP_FLUSH;
      S_FLUSH_WAIT: begin
        if (!busy) begin
          cmd.op    = glc_pkg::OP_RESTART;
          cmd.code  = clear_code;
          cmd.width = cs + 4'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      cs                <= glc_pkg::RESET_SIZE;
      prefix_code       <= 12'd0;
      have_prefix       <= 1'b0;
      chain_length      <= 4'd1;
      short_chain_count <= 5'd0;
      highest_code      <= (12'd1 << glc_pkg::RESET_SIZE) + 12'd1;
      code_width        <= glc_pkg::RESET_SIZE + 4'd1;
      cmp_valid         <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cfg_valid) begin
            cs                <= cs_new;
            prefix_code       <= 12'd0;
            have_prefix       <= 1'b0;
            chain_length      <= 4'd1;
            short_chain_count <= 5'd0;
            highest_code      <= (12'd1 << cs_new) + 12'd1;
            code_width        <= cs_new + 4'd1;
          end else if (in_valid) begin
            px    <= pixel & px_mask;
            last  <= last_pixel;
            state <= S_START;
          end
        end
        S_START: begin
          if (!have_prefix) begin
            prefix_code <= {4'd0, px};
            have_prefix <= 1'b1;
            state       <= S_LAST;
          end else begin
            scan_addr <= {1'b0, end_code} + 13'd1;
            cmp_valid <= 1'b0;
            state     <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          // one read issued and one compare per cycle
          if (hit) begin
            prefix_code <= cmp_addr;
            if (chain_length < 4'd15) chain_length <= chain_length + 4'd1;
            cmp_valid <= 1'b0;
            state     <= S_DRAIN;
          end else if (scan_addr <= {1'b0, highest_code}) begin
            cmp_valid <= 1'b1;
            cmp_addr  <= scan_addr[11:0];
            scan_addr <= scan_addr + 13'd1;
          end else begin
            cmp_valid <= 1'b0;
            state     <= S_MISS;
          end
        end
        S_MISS: begin
          if (wr_en) begin
            highest_code <= highest_next;
            if (code_width < glc_pkg::MAX_WIDTH &&
                {1'b0, highest_next} == (13'd1 << code_width))
              code_width <= code_width + 4'd1;
          end else if (code_width < glc_pkg::MAX_WIDTH &&
                       {1'b0, highest_code} == (13'd1 << code_width)) begin
            code_width <= code_width + 4'd1;
          end
          prefix_code <= {4'd0, px};
          if (code_width > cs + 4'd2) begin
            if (chain_x_size <= {4'd0, code_width})
              short_chain_count <= short_chain_count + 5'd1;
            else if (short_chain_count != 5'd0)
              short_chain_count <= short_chain_count - 5'd1;
          end
          chain_length <= 4'd1;
          state        <= S_CLEAR;
        end
        S_CLEAR: begin
          if (short_chain_count > {1'b0, cs} + 5'd8) begin
            highest_code      <= end_code;
            code_width        <= cs + 4'd1;
            short_chain_count <= 5'd0;
          end
          state <= S_DRAIN;
        end
        S_DRAIN: state <= S_DRAIN_WAIT;
        S_DRAIN_WAIT: begin
          if (!busy) state <= S_LAST;
        end
        S_LAST: begin
          if (last) begin
            // decoder widens after the final prefix
            if (code_width < glc_pkg::MAX_WIDTH &&
                highest_code < glc_pkg::TOP_CODE_LIMIT &&
                {1'b0, highest_next} == (13'd1 << code_width))
              code_width <= code_width + 4'd1;
            state <= S_END;
          end else begin
            state <= S_IDLE;
          end
        end
        S_END:   state <= S_FLUSH;
        S_FLUSH: state <= S_FLUSH_WAIT;
        S_FLUSH_WAIT: begin
          if (!busy) begin
            prefix_code       <= 12'd0;
            have_prefix       <= 1'b0;
            chain_length      <= 4'd1;
            short_chain_count <= 5'd0;
            highest_code      <= end_code;
            code_width        <= cs + 4'd1;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_write_only_on_miss: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_MISS && highest_next > end_code))
    else $error("dictionary write outside miss");
  a_hit_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH && hit) |-> (cmp_addr > end_code && cmp_addr <= highest_code))
    else $error("hit outside the live table");
  a_width_bounds: assert property (@(posedge clk) disable iff (rst)
    (code_width <= glc_pkg::MAX_WIDTH && code_width >= cs + 4'd1))
    else $error("code width out of range");
  a_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item taken while busy");
`endif

endmodule

// File: rtl/glc_dict_ram.sv
module glc_dict_ram #(
  parameter int ADDR_W = 12,
  parameter int DATA_W = 20
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/glc_bit_packer.sv
module glc_bit_packer (
  input  logic               clk,
  input  logic               rst,
  input  glc_pkg::pack_cmd_t cmd,
  output logic               busy,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         code_byte,
  output logic               stream_end
);

  typedef enum logic [2:0] {
    M_IDLE  = 3'b001,
    M_DRAIN = 3'b010,
    M_FLUSH = 3'b100
  } mode_t;

  mode_t       mode;
  logic [31:0] acc;
  logic [4:0]  cnt;
  logic        slot_free;
  logic        emit;

  assign slot_free = !out_valid || out_ready;
  assign busy = (mode != M_IDLE);
  assign emit = slot_free && ((mode == M_DRAIN && cnt >= 5'd8) ||
                              (mode == M_FLUSH && cnt != 5'd0));

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= M_IDLE;
      acc       <= 32'd1 << glc_pkg::RESET_SIZE;
      cnt       <= 5'({1'b0, glc_pkg::RESET_SIZE} + 5'd1);
      out_valid <= 1'b0;
    end else begin
      out_valid <= emit || (out_valid && !out_ready);
      case (mode)
        M_IDLE: begin
          case (cmd.op)
            glc_pkg::OP_PUT: begin
              acc <= acc | (32'(cmd.code) << cnt);
              cnt <= cnt + {1'b0, cmd.width};
            end
            glc_pkg::OP_DRAIN:   mode <= M_DRAIN;
            glc_pkg::OP_FLUSH:   mode <= M_FLUSH;
            glc_pkg::OP_RESTART: begin
              acc <= 32'(cmd.code);
              cnt <= {1'b0, cmd.width};
            end
            default: ;
          endcase
        end
        M_DRAIN: begin
          if (cnt < 5'd8) begin
            mode <= M_IDLE;
          end else if (slot_free) begin
            code_byte  <= acc[7:0];
            stream_end <= 1'b0;
            acc        <= acc >> 8;
            cnt        <= cnt - 5'd8;
          end
        end
        M_FLUSH: begin
          if (cnt == 5'd0) begin
            mode <= M_IDLE;
          end else if (slot_free) begin
            code_byte  <= acc[7:0];
            stream_end <= (cnt <= 5'd8);
            acc        <= acc >> 8;
            cnt        <= (cnt > 5'd8) ? cnt - 5'd8 : 5'd0;
          end
        end
        default: mode <= M_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_drain_leaves_partial: assert property (@(posedge clk) disable iff (rst)
    (mode == M_DRAIN && cnt < 5'd8) |=> (mode == M_IDLE && cnt < 5'd8))
    else $error("drain left a full byte");
  a_flush_empties: assert property (@(posedge clk) disable iff (rst)
    (mode == M_FLUSH && cnt == 5'd0) |=> mode == M_IDLE)
    else $error("flush did not finish");
  a_end_on_last: assert property (@(posedge clk) disable iff (rst)
    (mode == M_FLUSH && slot_free && cnt != 5'd0 && cnt <= 5'd8) |=> stream_end)
    else $error("final byte not marked");
`endif

endmodule
